// File: sv/bba_pkg.sv
package bba_pkg;

	localparam int BLK_W       = 13;
	localparam int ADDR_W      = 48;
	localparam int BLK_CAP     = 8191;
	localparam int WORD_W      = 32;
	localparam int WORD_SEL_W  = 5;
	localparam int WORD_AW     = BLK_W - WORD_SEL_W;
	localparam int GRP_W       = 8;
	localparam int GRP_SEL_W   = 3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_RUN  = 2'd1;
	localparam logic [1:0] STAT_OUTSIDE = 2'd2;

	localparam logic REG_REGION_BASE   = 1'b0;
	localparam logic REG_REGION_BLOCKS = 1'b1;

	localparam logic [BLK_W-1:0] REGION_BLOCKS_RST = 13'd4096;

	typedef struct packed {
		logic             found;
		logic [BLK_W-1:0] run;
		logic [BLK_W-1:0] start;
	} bba_scan_t;

	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [WORD_AW-1:0] rd_word;
		logic [WORD_AW-1:0] wr_word;
		logic [WORD_W-1:0]  wr_data;
	} bba_mem_req_t;

endpackage

// File: sv/bitmap_block_allocator_core.sv
// Bitmap block allocator: one used bit per block, first-fit run search.
// Request channel: start with opcode, block_count and free_address; a request
// is taken at a clock edge where start is high and busy is low. busy stays
// high until the result is out.
// Result channel: done is high for one cycle with alloc_address, status and
// used_blocks; the receiver cannot hold it off, and a new request may be
// taken in that same cycle.
// Configuration: cfg_we, cfg_index (0 region_base, 1 region_blocks) and
// cfg_wdata; the user must write them only while idle, the block does not enforce it.
// Allocate scans 8-block groups from the hint and then marks the 32-bit bitmap
// words touched by the run; it answers without a scan when the count is zero or
// the hint is at or past the region end, and after the scan when no run is found.
// Free turns the offset into a block number with one reciprocal multiply and
// then clears the run; it answers early below the base or far past the region
// end, and after the block-number check when otherwise outside or count 0.
// The scan handles one 8-block group per cycle out of a registered word read
// of the bitmap memory; marking and clearing take one word per cycle.
// Reset clears the hint and the used count, and each bitmap word carries a
// valid flag so the whole map reads as free at once: no clearing pass.
module bitmap_block_allocator_core #(
	parameter int NUM_BLOCKS  = 4096,
	parameter int BLOCK_BYTES = 4096,
	parameter int ADDR_BITS   = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        opcode,
	input  logic [bba_pkg::BLK_W-1:0]   block_count,
	input  logic [bba_pkg::ADDR_W-1:0]  free_address,
	output logic                        done,
	output logic [bba_pkg::ADDR_W-1:0]  alloc_address,
	output logic [1:0]                  status,
	output logic [bba_pkg::BLK_W-1:0]   used_blocks,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [bba_pkg::ADDR_W-1:0]  cfg_wdata
);
	import bba_pkg::*;

	localparam int NB_CAP    = (NUM_BLOCKS > BLK_CAP) ? BLK_CAP : NUM_BLOCKS;
	localparam int MEM_WORDS = (NB_CAP + WORD_W - 1) / WORD_W;
	localparam int AW        = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam longint unsigned QLIM = (longint'(1) << BLK_W) * longint'(BLOCK_BYTES);
	localparam int RW        = $clog2(QLIM);
	localparam int PW        = BLK_W + $clog2(BLOCK_BYTES + 1);
	localparam int DIV_SH    = RW + $clog2(BLOCK_BYTES);
	localparam longint unsigned RCP = ((longint'(1) << DIV_SH) + longint'(BLOCK_BYTES) - 1)
	                                / longint'(BLOCK_BYTES);
	localparam int RCW       = $clog2(RCP + 1);
	localparam int DPW       = RW + RCW;
	localparam logic [BLK_W-1:0] CAP_V = BLK_W'(NB_CAP);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_MARK = 3'd2;
	localparam logic [2:0] S_FSUB = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_FCHK = 3'd5;
	localparam logic [2:0] S_MUL  = 3'd6;
	localparam logic [2:0] S_ADD  = 3'd7;

	logic [2:0]        state_q, state_d;
	logic              done_q, done_d;
	logic [BLK_W-1:0]  hint_q, hint_d;
	logic [BLK_W-1:0]  used_q, used_d;
	logic [ADDR_W-1:0] region_base_q;
	logic [BLK_W-1:0]  region_blocks_q;

	logic [BLK_W-1:0]  pos_q, pos_d;
	logic [BLK_W-1:0]  run_q, run_d;
	logic [BLK_W-1:0]  start_q, start_d;
	logic [BLK_W-1:0]  count_q, count_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [RW-1:0]     rem_q, rem_d;
	logic [BLK_W-1:0]  quo_q, quo_d;
	logic [BLK_W-1:0]  mark_ptr_q, mark_ptr_d;
	logic [BLK_W-1:0]  mark_end_q, mark_end_d;
	logic              set_q, set_d;
	logic [PW-1:0]     prod_q, prod_d;
	logic [ADDR_W-1:0] res_addr_q, res_addr_d;
	logic [1:0]        res_stat_q, res_stat_d;
	logic [BLK_W-1:0]  res_used_q, res_used_d;

	logic [BLK_W-1:0]           limit;
	bba_mem_req_t               mreq;
	logic [WORD_W-1:0]          rd_data;
	logic [GRP_W-1:0]           grp_bits;
	bba_scan_t                  ctx_in, ctx_out;
	logic [BLK_W-GRP_SEL_W:0]   next_grp;
	logic [BLK_W:0]             next_pos;
	logic                       past_end;
	logic [ADDR_W:0]            fsub;
	logic [AW-1:0]              diff_aw;
	logic [DPW-1:0]             div_prod;
	logic                       mark_last;
	logic [WORD_SEL_W-1:0]      mark_hi;
	logic [WORD_W-1:0]          mark_mask;
	logic [AW-1:0]              sum_aw;
	logic [BLK_W-1:0]           used_sub;

	assign limit = (region_blocks_q > CAP_V) ? CAP_V : region_blocks_q;
	assign busy  = (state_q != S_IDLE);

	bba_bitmap #(
		.WORDS (MEM_WORDS)
	) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.rd_data (rd_data)
	);

	assign grp_bits = rd_data[{pos_q[WORD_SEL_W-1:GRP_SEL_W], {GRP_SEL_W{1'b0}}} +: GRP_W];
	assign ctx_in   = '{found: 1'b0, run: run_q, start: start_q};

	bba_group_scan u_group_scan (
		.grp_used (grp_bits),
		.grp_base ({pos_q[BLK_W-1:GRP_SEL_W], {GRP_SEL_W{1'b0}}}),
		.first    (pos_q[GRP_SEL_W-1:0]),
		.limit    (limit),
		.count    (count_q),
		.ctx_in   (ctx_in),
		.ctx_out  (ctx_out)
	);

	assign next_grp = {1'b0, pos_q[BLK_W-1:GRP_SEL_W]} + (BLK_W-GRP_SEL_W+1)'(1);
	assign next_pos = {next_grp, {GRP_SEL_W{1'b0}}};
	assign past_end = next_pos >= {1'b0, limit};

	assign fsub    = {1'b0, addr_q} - {1'b0, region_base_q};
	assign diff_aw = fsub[AW-1:0];
	// reciprocal multiply, exact for every offset below 2^RW
	assign div_prod = DPW'(rem_q) * DPW'(RCP);

	assign mark_last = (mark_ptr_q[BLK_W-1:WORD_SEL_W] == mark_end_q[BLK_W-1:WORD_SEL_W]);
	assign mark_hi   = mark_last ? mark_end_q[WORD_SEL_W-1:0] : '1;
	assign mark_mask = ({WORD_W{1'b1}} << mark_ptr_q[WORD_SEL_W-1:0])
	                 & ({WORD_W{1'b1}} >> (WORD_SEL_W'(WORD_W - 1) - mark_hi));

	assign sum_aw   = region_base_q[AW-1:0] + AW'(prod_q);
	assign used_sub = (used_q > count_q) ? (used_q - count_q) : '0;

	always_comb begin
		state_d    = state_q;
		done_d     = 1'b0;
		hint_d     = hint_q;
		used_d     = used_q;
		pos_d      = pos_q;
		run_d      = run_q;
		start_d    = start_q;
		count_d    = count_q;
		addr_d     = addr_q;
		rem_d      = rem_q;
		quo_d      = quo_q;
		mark_ptr_d = mark_ptr_q;
		mark_end_d = mark_end_q;
		set_d      = set_q;
		prod_d     = prod_q;
		res_addr_d = res_addr_q;
		res_stat_d = res_stat_q;
		res_used_d = res_used_q;
		mreq       = '0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					count_d = block_count;
					addr_d  = free_address;
					if (opcode == OP_FREE) begin
						state_d = S_FSUB;
					end else if (block_count == '0 || hint_q >= limit) begin
						done_d     = 1'b1;
						res_addr_d = '0;
						res_stat_d = STAT_NO_RUN;
						res_used_d = used_q;
					end else begin
						pos_d        = hint_q;
						run_d        = '0;
						start_d      = hint_q;
						mreq.rd_en   = 1'b1;
						mreq.rd_word = hint_q[BLK_W-1:WORD_SEL_W];
						state_d      = S_SCAN;
					end
				end
			end

			S_SCAN: begin
				if (ctx_out.found) begin
					start_d      = ctx_out.start;
					mark_ptr_d   = ctx_out.start;
					mark_end_d   = ctx_out.start + count_q - BLK_W'(1);
					set_d        = 1'b1;
					mreq.rd_en   = 1'b1;
					mreq.rd_word = ctx_out.start[BLK_W-1:WORD_SEL_W];
					state_d      = S_MARK;
				end else if (past_end) begin
					done_d     = 1'b1;
					res_addr_d = '0;
					res_stat_d = STAT_NO_RUN;
					res_used_d = used_q;
					state_d    = S_IDLE;
				end else begin
					pos_d   = next_pos[BLK_W-1:0];
					run_d   = ctx_out.run;
					start_d = ctx_out.start;
					// fetch the next word once the last group of this one is done
					if (pos_q[WORD_SEL_W-1:GRP_SEL_W] == '1) begin
						mreq.rd_en   = 1'b1;
						mreq.rd_word = next_pos[BLK_W-1:WORD_SEL_W];
					end
				end
			end

			S_MARK: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_word = mark_ptr_q[BLK_W-1:WORD_SEL_W];
				mreq.wr_data = set_q ? (rd_data | mark_mask) : (rd_data & ~mark_mask);
				if (mark_last) begin
					if (set_q) begin
						state_d = S_MUL;
					end else begin
						used_d     = used_sub;
						done_d     = 1'b1;
						res_addr_d = '0;
						res_stat_d = STAT_OK;
						res_used_d = used_sub;
						state_d    = S_IDLE;
					end
				end else begin
					mark_ptr_d   = {mark_ptr_q[BLK_W-1:WORD_SEL_W] + WORD_AW'(1),
					                {WORD_SEL_W{1'b0}}};
					mreq.rd_en   = 1'b1;
					mreq.rd_word = mark_ptr_q[BLK_W-1:WORD_SEL_W] + WORD_AW'(1);
				end
			end

			S_FSUB: begin
				if (fsub[ADDR_W] || 64'(diff_aw) >= QLIM) begin
					done_d     = 1'b1;
					res_addr_d = '0;
					res_stat_d = STAT_OUTSIDE;
					res_used_d = used_q;
					state_d    = S_IDLE;
				end else begin
					rem_d   = RW'(diff_aw);
					state_d = S_DIV;
				end
			end

			S_DIV: begin
				quo_d   = BLK_W'(div_prod >> DIV_SH);
				state_d = S_FCHK;
			end

			S_FCHK: begin
				if (quo_q >= limit || count_q > (limit - quo_q)) begin
					done_d     = 1'b1;
					res_addr_d = '0;
					res_stat_d = STAT_OUTSIDE;
					res_used_d = used_q;
					state_d    = S_IDLE;
				end else begin
					if (quo_q < hint_q) begin
						hint_d = quo_q;
					end
					if (count_q == '0) begin
						done_d     = 1'b1;
						res_addr_d = '0;
						res_stat_d = STAT_OK;
						res_used_d = used_q;
						state_d    = S_IDLE;
					end else begin
						mark_ptr_d   = quo_q;
						mark_end_d   = quo_q + count_q - BLK_W'(1);
						set_d        = 1'b0;
						mreq.rd_en   = 1'b1;
						mreq.rd_word = quo_q[BLK_W-1:WORD_SEL_W];
						state_d      = S_MARK;
					end
				end
			end

			S_MUL: begin
				prod_d  = PW'(start_q) * PW'(BLOCK_BYTES);
				state_d = S_ADD;
			end

			S_ADD: begin
				used_d = used_q + count_q;
				if (count_q == BLK_W'(1)) begin
					hint_d = start_q + BLK_W'(1);
				end
				done_d     = 1'b1;
				res_addr_d = ADDR_W'(sum_aw);
				res_stat_d = STAT_OK;
				res_used_d = used_q + count_q;
				state_d    = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			done_q          <= 1'b0;
			hint_q          <= '0;
			used_q          <= '0;
			region_base_q   <= '0;
			region_blocks_q <= REGION_BLOCKS_RST;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			hint_q  <= hint_d;
			used_q  <= used_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_REGION_BASE:   region_base_q   <= cfg_wdata;
					REG_REGION_BLOCKS: region_blocks_q <= cfg_wdata[BLK_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q      <= pos_d;
		run_q      <= run_d;
		start_q    <= start_d;
		count_q    <= count_d;
		addr_q     <= addr_d;
		rem_q      <= rem_d;
		quo_q      <= quo_d;
		mark_ptr_q <= mark_ptr_d;
		mark_end_q <= mark_end_d;
		set_q      <= set_d;
		prod_q     <= prod_d;
		res_addr_q <= res_addr_d;
		res_stat_q <= res_stat_d;
		res_used_q <= res_used_d;
	end

	assign done          = done_q;
	assign alloc_address = res_addr_q;
	assign status        = res_stat_q;
	assign used_blocks   = res_used_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a request is still in progress");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted request neither started nor answered");

	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MARK |-> mark_ptr_q <= mark_end_q)
		else $error("mark pointer ran past the end of the run");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.rd_en && mreq.wr_en |-> mreq.rd_word != mreq.wr_word)
		else $error("bitmap read and write hit the same word");

endmodule

// File: sv/bba_bitmap.sv
module bba_bitmap #(
	parameter int WORDS = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bba_pkg::bba_mem_req_t       req,
	output logic [bba_pkg::WORD_W-1:0]  rd_data
);
	import bba_pkg::*;

	localparam int MAW = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [WORD_W-1:0] mem [0:WORDS-1];
	logic [WORD_W-1:0] rd_word_q;
	logic [WORDS-1:0]  vld_q;
	logic              rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_word[MAW-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_word_q <= mem[req.rd_word[MAW-1:0]];
		end
	end

	// a word never written since reset reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_word[MAW-1:0]] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_word[MAW-1:0]];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

// File: sv/bba_group_scan.sv
module bba_group_scan (
	input  logic [bba_pkg::GRP_W-1:0]     grp_used,
	input  logic [bba_pkg::BLK_W-1:0]     grp_base,
	input  logic [bba_pkg::GRP_SEL_W-1:0] first,
	input  logic [bba_pkg::BLK_W-1:0]     limit,
	input  logic [bba_pkg::BLK_W-1:0]     count,
	input  bba_pkg::bba_scan_t            ctx_in,
	output bba_pkg::bba_scan_t            ctx_out
);
	import bba_pkg::*;

	always_comb begin
		bba_scan_t        ctx;
		logic [BLK_W-1:0] p;
		ctx = ctx_in;
		ctx.found = 1'b0;
		for (int j = 0; j < GRP_W; j++) begin
			p = grp_base | BLK_W'(j);
			if (!ctx.found && GRP_SEL_W'(j) >= first && p < limit) begin
				if (grp_used[j]) begin
					// restart the run just past a used block
					ctx.run   = '0;
					ctx.start = p + BLK_W'(1);
				end else begin
					ctx.run = ctx.run + BLK_W'(1);
					if (ctx.run == count) begin
						ctx.found = 1'b1;
					end
				end
			end
		end
		ctx_out = ctx;
	end

endmodule

// File: tb/tb_bitmap_block_allocator_core.sv
module tb_bitmap_block_allocator_core;
	import bba_pkg::*;

	localparam int NUM_BLOCKS      = 4096;
	localparam int BLOCK_BYTES     = 4096;
	localparam int ADDR_BITS       = 48;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int DRAIN_CYCLES    = 4;
	// longest allocate: 512 groups scanned plus 128 words marked
	localparam int SETTLE_CYCLES   = 700;
	localparam int STALL_LIMIT     = 4000;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [1:0]        status_code;
		logic [BLK_W-1:0]  used;
	} outcome_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [BLK_W-1:0]  blocks;
	} run_t;

	typedef struct packed {
		logic              is_cfg;
		logic              op;
		logic [BLK_W-1:0]  cnt;
		logic [ADDR_W-1:0] addr;
		logic              typed;
		outcome_t          want;
	} step_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              opcode = OP_ALLOC;
	logic [BLK_W-1:0]  block_count = '0;
	logic [ADDR_W-1:0] free_address = '0;
	logic              done;
	logic [ADDR_W-1:0] alloc_address;
	logic [1:0]        status;
	logic [BLK_W-1:0]  used_blocks;
	logic              cfg_we = 1'b0;
	logic              cfg_index = REG_REGION_BASE;
	logic [ADDR_W-1:0] cfg_wdata = '0;

	// allocator state as the block should hold it
	bit                used_map [NUM_BLOCKS];
	int unsigned       search_hint;
	int unsigned       blocks_in_use;
	logic [ADDR_W-1:0] region_base_q;
	logic [BLK_W-1:0]  region_blocks_q;

	outcome_t owed_outcomes [$];
	run_t     held_runs [$];
	logic     quiet_phase = 1'b0;
	int       errors = 0;
	int       idle_cycles = 0;
	int       requests_sent = 0;
	int       settings_used = 0;
	int       n_placed = 0;
	int       n_no_run = 0;
	int       n_released = 0;
	int       n_outside = 0;

	step_row_t directed_steps [0:26] = '{
		'{1'b0, OP_ALLOC, 13'd0, 48'd0, 1'b1, '{48'd0, STAT_NO_RUN, 13'd0}},
		'{1'b0, OP_ALLOC, 13'd1, 48'd0, 1'b1, '{48'd0, STAT_OK, 13'd1}},
		'{1'b0, OP_ALLOC, 13'd1, 48'd0, 1'b1, '{48'h1000, STAT_OK, 13'd2}},
		'{1'b0, OP_ALLOC, 13'd4096, 48'd0, 1'b1, '{48'd0, STAT_NO_RUN, 13'd2}},
		'{1'b0, OP_ALLOC, 13'd8191, 48'hFFFF_FFFF_FFFF, 1'b1, '{48'd0, STAT_NO_RUN, 13'd2}},
		'{1'b0, OP_FREE, 13'd1, 48'd0, 1'b1, '{48'd0, STAT_OK, 13'd1}},
		'{1'b0, OP_FREE, 13'd1, 48'd0, 1'b1, '{48'd0, STAT_OK, 13'd0}},
		'{1'b0, OP_ALLOC, 13'd1, 48'd0, 1'b1, '{48'd0, STAT_OK, 13'd1}},
		'{1'b0, OP_FREE, 13'd1, 48'h1001, 1'b0, '0},
		'{1'b0, OP_FREE, 13'd1, 48'd0, 1'b0, '0},
		'{1'b0, OP_FREE, 13'd0, 48'd0, 1'b0, '0},
		'{1'b0, OP_FREE, 13'd1, 48'h100_0000, 1'b1, '{48'd0, STAT_OUTSIDE, 13'd0}},
		'{1'b0, OP_FREE, 13'd1, 48'hFFFF_FFFF_FFFF, 1'b1, '{48'd0, STAT_OUTSIDE, 13'd0}},
		'{1'b0, OP_FREE, 13'd4097, 48'd0, 1'b1, '{48'd0, STAT_OUTSIDE, 13'd0}},
		'{1'b0, OP_ALLOC, 13'd4096, 48'd0, 1'b1, '{48'd0, STAT_OK, 13'd4096}},
		'{1'b0, OP_ALLOC, 13'd1, 48'd0, 1'b1, '{48'd0, STAT_NO_RUN, 13'd4096}},
		'{1'b0, OP_FREE, 13'd4096, 48'd0, 1'b1, '{48'd0, STAT_OK, 13'd0}},
		'{1'b0, OP_FREE, 13'd8191, 48'd0, 1'b1, '{48'd0, STAT_OUTSIDE, 13'd0}},
		'{1'b1, OP_ALLOC, 13'd1, 48'hFFFF_FFFF_FFFF, 1'b0, '0},
		'{1'b0, OP_ALLOC, 13'd1, 48'd0, 1'b1, '{48'hFFFF_FFFF_FFFF, STAT_OK, 13'd1}},
		'{1'b0, OP_ALLOC, 13'd1, 48'd0, 1'b1, '{48'd0, STAT_NO_RUN, 13'd1}},
		'{1'b0, OP_FREE, 13'd1, 48'd0, 1'b1, '{48'd0, STAT_OUTSIDE, 13'd1}},
		'{1'b0, OP_FREE, 13'd1, 48'hFFFF_FFFF_FFFF, 1'b1, '{48'd0, STAT_OK, 13'd0}},
		'{1'b1, OP_ALLOC, 13'd4096, 48'hFFFF_FFFF_8000, 1'b0, '0},
		'{1'b0, OP_ALLOC, 13'd16, 48'd0, 1'b0, '0},
		'{1'b0, OP_ALLOC, 13'd16, 48'd0, 1'b0, '0},
		// the second run wrapped past the top of the address space
		'{1'b0, OP_FREE, 13'd16, 48'h8000, 1'b0, '0}
	};

	bitmap_block_allocator_core #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES),
		.ADDR_BITS   (ADDR_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.block_count   (block_count),
		.free_address  (free_address),
		.done          (done),
		.alloc_address (alloc_address),
		.status        (status),
		.used_blocks   (used_blocks),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic int unsigned active_limit();
		return (region_blocks_q > NUM_BLOCKS) ? NUM_BLOCKS : int'(region_blocks_q);
	endfunction

	// first-fit placement or release of a run; updates the map, hint and count
	function automatic outcome_t place_or_release(input logic op, input logic [BLK_W-1:0] cnt,
			input logic [ADDR_W-1:0] addr);
		outcome_t          res;
		int unsigned       limit;
		int unsigned       first;
		int unsigned       run_len;
		int unsigned       blk;
		longint unsigned   start_blk;
		logic              found;
		limit = active_limit();
		res = '0;
		if (op == OP_ALLOC) begin
			found = 1'b0;
			res.status_code = STAT_NO_RUN;
			if (cnt != 0) begin
				first = search_hint;
				run_len = 0;
				for (blk = search_hint; blk < limit && !found; blk++) begin
					if (used_map[blk]) begin
						run_len = 0;
						first = blk + 1;
					end else begin
						run_len++;
						if (run_len >= cnt)
							found = 1'b1;
					end
				end
			end
			if (found) begin
				for (blk = first; blk < first + cnt; blk++)
					used_map[blk] = 1'b1;
				blocks_in_use += cnt;
				if (cnt == 1)
					search_hint = first + 1;
				res.address = region_base_q + ADDR_W'(first) * ADDR_W'(BLOCK_BYTES);
				res.status_code = STAT_OK;
				n_placed++;
			end else begin
				n_no_run++;
			end
		end else begin
			res.status_code = STAT_OUTSIDE;
			if (addr >= region_base_q) begin
				start_blk = 64'(addr - region_base_q) / 64'(BLOCK_BYTES);
				if (start_blk < limit && 64'(cnt) <= 64'(limit) - start_blk) begin
					first = 32'(start_blk);
					res.status_code = STAT_OK;
					if (first < search_hint)
						search_hint = first;
					for (blk = first; blk < first + cnt; blk++)
						used_map[blk] = 1'b0;
					blocks_in_use = (blocks_in_use > cnt) ? blocks_in_use - cnt : 0;
				end
			end
			if (res.status_code == STAT_OK)
				n_released++;
			else
				n_outside++;
		end
		res.used = BLK_W'(blocks_in_use);
		return res;
	endfunction

	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 200);
	endfunction

	function automatic logic [BLK_W-1:0] alloc_count(input int unsigned limit);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 13'd1;
		if (r < 85)
			return BLK_W'($urandom_range(2, 8));
		if (r < 93)
			return BLK_W'($urandom_range(9, 64));
		if (r < 97)
			return BLK_W'($urandom_range(65, (limit > 65) ? limit : 65));
		if (r < 99)
			return 13'd0;
		return BLK_W'($urandom_range(4097, 8191));
	endfunction

	task automatic issue_request(input logic op, input logic [BLK_W-1:0] cnt,
			input logic [ADDR_W-1:0] addr, input logic typed, input outcome_t want);
		outcome_t    got;
		int unsigned gap;
		start <= 1'b1;
		opcode <= op;
		block_count <= cnt;
		free_address <= addr;
		do @(posedge clk); while (busy);
		got = place_or_release(op, cnt, addr);
		owed_outcomes.push_back(typed ? want : got);
		if (op == OP_ALLOC && got.status_code == STAT_OK)
			held_runs.push_back('{got.address, cnt});
		requests_sent++;
		gap = draw_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_until_idle();
		start <= 1'b0;
		while (owed_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_region(input logic [ADDR_W-1:0] base, input logic [BLK_W-1:0] blocks,
			input logic [ADDR_W-BLK_W-1:0] junk);
		wait_until_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_REGION_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= REG_REGION_BLOCKS;
		cfg_wdata <= {junk, blocks};
		@(posedge clk);
		cfg_we <= 1'b0;
		region_base_q = base;
		region_blocks_q = blocks;
		settings_used++;
	endtask

	// free a run handed out earlier; now and then keep it for a redundant free
	// or shorten it by one block
	task automatic release_held_run();
		int unsigned       pick;
		int unsigned       r;
		run_t              run;
		logic [ADDR_W-1:0] addr;
		logic [BLK_W-1:0]  cnt;
		pick = $urandom_range(0, held_runs.size() - 1);
		run = held_runs[pick];
		r = $urandom_range(0, 99);
		if (r >= 5)
			held_runs.delete(pick);
		cnt = (r >= 5 && r < 10 && run.blocks > 1) ? run.blocks - 13'd1 : run.blocks;
		addr = run.address;
		if ($urandom_range(0, 3) == 0)
			addr = addr + ADDR_W'($urandom_range(1, BLOCK_BYTES - 1));
		issue_request(OP_FREE, cnt, addr, 1'b0, '0);
	endtask

	task automatic random_request();
		int unsigned       limit;
		int unsigned       r;
		logic [ADDR_W-1:0] addr;
		limit = active_limit();
		r = $urandom_range(0, 99);
		addr = {16'($urandom), $urandom};
		if (held_runs.size() != 0 && r < 40) begin
			release_held_run();
		end else if (r < 80) begin
			issue_request(OP_ALLOC, alloc_count(limit), addr, 1'b0, '0);
		end else if (r < 92) begin
			addr = region_base_q + ADDR_W'($urandom_range(0, limit + 1)) * ADDR_W'(BLOCK_BYTES);
			if ($urandom_range(0, 2) == 0)
				addr = addr + ADDR_W'($urandom_range(0, BLOCK_BYTES - 1));
			issue_request(OP_FREE, BLK_W'($urandom_range(0, 8)), addr, 1'b0, '0);
		end else begin
			issue_request(OP_FREE, BLK_W'($urandom_range(0, 8191)), addr, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && done) begin
			if (owed_outcomes.size() == 0) begin
				$error("unexpected result: alloc_address %h status %0d used_blocks %0d",
					alloc_address, status, used_blocks);
				errors++;
			end else begin
				want = owed_outcomes.pop_front();
				if (alloc_address !== want.address) begin
					$error("alloc_address: expected %h, got %h", want.address, alloc_address);
					errors++;
				end
				if (status !== want.status_code) begin
					$error("status: expected %0d, got %0d", want.status_code, status);
					errors++;
				end
				if (used_blocks !== want.used) begin
					$error("used_blocks: expected %0d, got %0d", want.used, used_blocks);
					errors++;
				end
			end
		end
	end

	// count cycles with neither a request taken nor a result out
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		step_row_t         row;
		logic [ADDR_W-1:0] base;
		logic [BLK_W-1:0]  blocks;
		region_base_q = '0;
		region_blocks_q = REGION_BLOCKS_RST;
		search_hint = 0;
		blocks_in_use = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			row = directed_steps[i];
			if (row.is_cfg)
				program_region(row.addr, row.cnt, '0);
			else
				issue_request(row.op, row.cnt, row.addr, row.typed, row.want);
		end

		// leftovers belong to an old base address
		held_runs.delete();
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: blocks = 13'd4096;
				1: blocks = BLK_W'($urandom_range(1, 8));
				2: blocks = BLK_W'($urandom_range(9, 64));
				default: blocks = BLK_W'($urandom_range(65, 4096));
			endcase
			if (phase == 0) begin
				base = '0;
			end else if (phase == 1) begin
				base = 48'hFFFF_FFFF_F000 - ADDR_W'($urandom_range(0, 8)) * ADDR_W'(BLOCK_BYTES);
			end else begin
				base = {16'($urandom), $urandom};
				if ($urandom_range(0, 3) != 0)
					base[11:0] = '0;
			end
			program_region(base, blocks, {3'($urandom), $urandom});
			quiet_phase = ($urandom_range(0, 3) == 0);
			repeat (ITEMS_PER_PHASE) random_request();
			while (held_runs.size() != 0)
				release_held_run();
		end

		wait_until_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d requests over %0d region settings", requests_sent, settings_used);
		$display("runs placed %0d, no run %0d, runs freed %0d, frees outside region %0d",
			n_placed, n_no_run, n_released, n_outside);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
